// File: sv/ess_pkg.sv
`default_nettype none
package ess_pkg;

	// input item commands
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_LOAD   = 2'd1;
	localparam logic [1:0] CMD_REWIND = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_POINT_COUNT = 2'd0;
	localparam logic [1:0] REG_MOD_FREQ    = 2'd1;
	localparam logic [1:0] REG_MOD_PHASE   = 2'd2;

	// sine polynomial coefficients, Q2.30
	localparam logic [31:0] SIN_A   = 32'd1686629713;
	localparam logic [31:0] SIN_B   = 32'd688904866;
	localparam logic [31:0] SIN_C   = 32'd76016977;
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_RD0,
		OP_RDPOS,
		OP_TAKE_CUR,
		OP_RDNEXT,
		OP_ADVANCE,
		OP_TAKE_NEXT,
		OP_HOLD,
		OP_IMUL,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_END,
		OP_PMUL,
		OP_PANG,
		OP_SQ,
		OP_MC,
		OP_MT,
		OP_MS,
		OP_MV,
		OP_SAT,
		OP_ZERO,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   in_load;
		logic   in_rewind;
		logic   in_tick;
	} dp_ctl_t;

	typedef struct packed {
		logic cnt_zero;
		logic before_first;
		logic has_next;
		logic next_le;
		logic num_pos;
		logic freq_zero;
	} dp_sts_t;

endpackage
`default_nettype wire

// File: sv/ess_ram.sv
`default_nettype none
module ess_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: sv/ess_datapath.sv
`default_nettype none
module ess_datapath #(
	parameter int ENV_DEPTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ess_pkg::dp_ctl_t ctl,
	output ess_pkg::dp_sts_t      sts,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [31:0]      cfg_data,
	input  wire logic [31:0]      now_time,
	input  wire logic [5:0]       point_slot,
	input  wire logic [31:0]      point_time,
	input  wire logic [31:0]      point_amplitude,
	output logic signed [31:0]    stim_value,
	output logic                  active
);
	import ess_pkg::*;

	localparam int PW = $clog2(ENV_DEPTH);
	localparam int KW = (PW + 1 > 7) ? PW + 1 : 7;

	logic [6:0]  point_count_q;
	logic [31:0] freq_q, phase_q;
	logic [PW-1:0] pos_q;
	logic [31:0] now_q, t0_q, a0_q, t1_q, a1_q, val_q, x2_q;
	logic [30:0] x_q;
	logic        sneg_q, vneg_q, dneg_q, act_q;
	logic [63:0] prod_q;
	logic [31:0] rem_q, dvd_q, quo_q;

	logic          ram_we;
	logic [PW-1:0] ram_raddr, pos_clamp;
	logic [63:0]   ram_rdata;
	logic [31:0]   rd_time, rd_amp;
	logic [KW-1:0] cnt, pc_ext, pos_ext, pos_nx;
	logic [32:0]   diff, diff_mag, rem_try;
	logic [31:0]   mul_a, mul_b, t_mc, t_ms, vmag, den;
	logic [31:0]   ang;
	logic [33:0]   mag_m;

	assign ram_we = ctl.in_load && (KW'(point_slot) < KW'(ENV_DEPTH));

	ess_ram #(.WIDTH(64), .DEPTH(ENV_DEPTH)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(PW'(point_slot)),
		.wdata({point_time, point_amplitude}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);
	assign rd_time = ram_rdata[63:32];
	assign rd_amp  = ram_rdata[31:0];

	assign pc_ext    = KW'(point_count_q);
	assign cnt       = (pc_ext > KW'(ENV_DEPTH)) ? KW'(ENV_DEPTH) : pc_ext;
	assign pos_ext   = KW'(pos_q);
	assign pos_nx    = pos_ext + KW'(1);
	assign pos_clamp = (pos_ext >= cnt) ? PW'(cnt - KW'(1)) : pos_q;

	always_comb begin
		case (ctl.op)
			OP_RDPOS:  ram_raddr = pos_clamp;
			OP_RDNEXT: ram_raddr = pos_q + PW'(1);
			default:   ram_raddr = '0;
		endcase
	end

	assign sts.cnt_zero     = (cnt == '0);
	assign sts.before_first = (now_q < rd_time);
	assign sts.has_next     = (pos_nx < cnt);
	assign sts.next_le      = (rd_time <= now_q);
	assign sts.num_pos      = (now_q > t0_q);
	assign sts.freq_zero    = (freq_q == '0);

	// interpolation terms
	assign diff     = {a1_q[31], a1_q} - {a0_q[31], a0_q};
	assign diff_mag = diff[32] ? -diff : diff;
	assign den      = t1_q - t0_q;
	assign rem_try  = {rem_q, dvd_q[31]} - {1'b0, den};

	// sine chain terms
	assign t_mc = SIN_B - prod_q[61:30];
	assign t_ms = SIN_A - prod_q[61:30];
	assign vmag = val_q[31] ? -val_q : val_q;
	assign ang  = prod_q[31:0] + phase_q;
	assign mag_m = prod_q[63:30];

	always_comb begin
		case (ctl.op)
			OP_IMUL: begin mul_a = diff_mag[31:0];   mul_b = now_q - t0_q;    end
			OP_PMUL: begin mul_a = freq_q;           mul_b = now_q;           end
			OP_SQ:   begin mul_a = 32'(x_q);         mul_b = 32'(x_q);        end
			OP_MC:   begin mul_a = SIN_C;            mul_b = prod_q[61:30];   end
			OP_MT:   begin mul_a = t_mc;             mul_b = x2_q;            end
			OP_MS:   begin mul_a = t_ms;             mul_b = 32'(x_q);        end
			OP_MV:   begin mul_a = vmag;             mul_b = prod_q[61:30];   end
			default: begin mul_a = '0;               mul_b = '0;              end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
			freq_q        <= '0;
			phase_q       <= '0;
			pos_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_POINT_COUNT: point_count_q <= cfg_data[6:0];
					REG_MOD_FREQ:    freq_q        <= cfg_data;
					REG_MOD_PHASE:   phase_q       <= cfg_data;
					default:         ;
				endcase
			end
			if (ctl.in_rewind) begin
				pos_q <= '0;
			end else if (ctl.op == OP_RDPOS) begin
				pos_q <= pos_clamp;
			end else if (ctl.op == OP_ADVANCE) begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.in_tick) begin
			now_q <= now_time;
		end
		case (ctl.op)
			OP_RDPOS: act_q <= 1'b1;
			OP_TAKE_CUR, OP_ADVANCE: begin
				t0_q <= rd_time;
				a0_q <= rd_amp;
			end
			OP_TAKE_NEXT: begin
				t1_q <= rd_time;
				a1_q <= rd_amp;
			end
			OP_HOLD: val_q <= a0_q;
			OP_IMUL: begin
				prod_q <= mul_a * mul_b;
				dneg_q <= diff[32];
			end
			OP_DIV_INIT: begin
				rem_q <= prod_q[63:32];
				dvd_q <= prod_q[31:0];
			end
			OP_DIV_STEP: begin
				if (!rem_try[32]) begin
					rem_q <= rem_try[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], dvd_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
				dvd_q <= {dvd_q[30:0], 1'b0};
			end
			OP_DIV_END: val_q <= dneg_q ? a0_q - quo_q : a0_q + quo_q;
			OP_PMUL: prod_q <= mul_a * mul_b;
			OP_PANG: begin
				x_q    <= ang[30] ? ONE_Q30 - {1'b0, ang[29:0]} : {1'b0, ang[29:0]};
				sneg_q <= ang[31];
			end
			OP_SQ: prod_q <= mul_a * mul_b;
			OP_MC: begin
				x2_q   <= prod_q[61:30];
				prod_q <= mul_a * mul_b;
			end
			OP_MT, OP_MS: prod_q <= mul_a * mul_b;
			OP_MV: begin
				prod_q <= mul_a * mul_b;
				vneg_q <= val_q[31] ^ sneg_q;
			end
			OP_SAT: begin
				if (!vneg_q) begin
					val_q <= (mag_m > 34'h07FFFFFFF) ? 32'h7FFFFFFF : mag_m[31:0];
				end else begin
					val_q <= (mag_m > 34'h080000000) ? 32'h80000000 : -mag_m[31:0];
				end
			end
			OP_ZERO: begin
				val_q <= '0;
				act_q <= 1'b0;
			end
			OP_OUT: begin
				stim_value <= val_q;
				active     <= act_q;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// File: sv/ess_ctrl.sv
`default_nettype none
module ess_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       cmd,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output ess_pkg::dp_ctl_t      ctl,
	input  wire ess_pkg::dp_sts_t sts
);
	import ess_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_RD0, S_RDP, S_CHK, S_RDN, S_INUM, S_DINIT, S_DIV,
		S_DEND, S_MODCHK, S_PANG, S_SQ, S_MC, S_MT, S_MS, S_MV, S_SAT, S_OUT
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] div_cnt_q;
	logic       accept, out_load;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == S_OUT) && (!out_valid || !out_stall);

	always_comb begin
		ctl.op        = OP_NONE;
		ctl.in_load   = accept && (cmd == CMD_LOAD);
		ctl.in_rewind = accept && (cmd == CMD_REWIND);
		ctl.in_tick   = accept && (cmd == CMD_TICK);
		state_d       = state_q;
		case (state_q)
			S_IDLE: if (ctl.in_tick) state_d = S_START;
			S_START: begin
				ctl.op  = sts.cnt_zero ? OP_ZERO : OP_RD0;
				state_d = sts.cnt_zero ? S_OUT : S_RD0;
			end
			S_RD0: begin
				ctl.op  = sts.before_first ? OP_ZERO : OP_RDPOS;
				state_d = sts.before_first ? S_OUT : S_RDP;
			end
			S_RDP: begin
				ctl.op  = OP_TAKE_CUR;
				state_d = S_CHK;
			end
			S_CHK: begin
				ctl.op  = sts.has_next ? OP_RDNEXT : OP_HOLD;
				state_d = sts.has_next ? S_RDN : S_MODCHK;
			end
			S_RDN: begin
				ctl.op  = sts.next_le ? OP_ADVANCE : OP_TAKE_NEXT;
				state_d = sts.next_le ? S_CHK : S_INUM;
			end
			S_INUM: begin
				ctl.op  = sts.num_pos ? OP_IMUL : OP_HOLD;
				state_d = sts.num_pos ? S_DINIT : S_MODCHK;
			end
			S_DINIT: begin
				ctl.op  = OP_DIV_INIT;
				state_d = S_DIV;
			end
			S_DIV: begin
				ctl.op = OP_DIV_STEP;
				if (div_cnt_q == 5'd31) state_d = S_DEND;
			end
			S_DEND: begin
				ctl.op  = OP_DIV_END;
				state_d = S_MODCHK;
			end
			S_MODCHK: begin
				ctl.op  = sts.freq_zero ? OP_NONE : OP_PMUL;
				state_d = sts.freq_zero ? S_OUT : S_PANG;
			end
			S_PANG: begin ctl.op = OP_PANG; state_d = S_SQ;  end
			S_SQ:   begin ctl.op = OP_SQ;   state_d = S_MC;  end
			S_MC:   begin ctl.op = OP_MC;   state_d = S_MT;  end
			S_MT:   begin ctl.op = OP_MT;   state_d = S_MS;  end
			S_MS:   begin ctl.op = OP_MS;   state_d = S_MV;  end
			S_MV:   begin ctl.op = OP_MV;   state_d = S_SAT; end
			S_SAT:  begin ctl.op = OP_SAT;  state_d = S_OUT; end
			S_OUT: begin
				if (out_load) begin
					ctl.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q + 5'd1;
			end else begin
				div_cnt_q <= '0;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// File: sv/envelope_sine_stimulus.sv
`default_nettype none
// One stimulus channel: a piecewise-linear envelope over up to ENV_DEPTH points, optionally
// multiplied by a sine. Load beats (cmd 1) write a point; rewind beats (cmd 2) reset the
// envelope position; neither returns a result. A tick beat (cmd 0) returns one result. It
// walks forward while the next point's time is at or before the tick time, then holds the
// last point, or the current point when the tick time is at or before it. Interpolating
// adds to the held case a next point read, setup, a 32-step restoring divider with one
// quotient bit a cycle and an end step, and a nonzero frequency adds the angle and sine
// steps (one shared 32x32 multiplier runs the interpolation product, the angle and the sine
// polynomial). After a result is handed off the block returns to idle before it takes the
// next beat. Input is taken one beat at a time; a finished result waits in an output
// register, so the next beat is taken while the result is still stalled. The point store
// is a RAM with no reset: reading a point never loaded gives an undefined result.
// Configuration writes are always ready and must only be made while no tick is in progress.
module envelope_sine_stimulus #(
	parameter int ENV_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input beats
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic [31:0]        now_time,
	input  wire logic [5:0]         point_slot,
	input  wire logic [31:0]        point_time,
	input  wire logic signed [31:0] point_amplitude,
	// result beats
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      stim_value,
	output logic                    active,
	// configuration writes
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import ess_pkg::*;

	dp_ctl_t ctl;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	// sequencer: walk, divide, sine steps and output hand-off
	ess_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ctl      (ctl),
		.sts      (sts)
	);

	// point store, registers, divider and multiplier
	ess_datapath #(.ENV_DEPTH(ENV_DEPTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.now_time       (now_time),
		.point_slot     (point_slot),
		.point_time     (point_time),
		.point_amplitude(point_amplitude),
		.stim_value     (stim_value),
		.active         (active)
	);
endmodule
`default_nettype wire

// File: sv/ess_checker.sv
`default_nettype none
module ess_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [1:0]  cmd,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] stim_value,
	input wire logic        active
);
	import ess_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(stim_value) && $stable(active))
		else $error("stalled result changed");

	// inactive result carries zero
	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active |-> stim_value == 32'd0)
		else $error("inactive result not zero");

	// a tick occupies the block
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_TICK |=> in_stall)
		else $error("tick did not occupy block");

	// load and rewind do not occupy the block
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == CMD_LOAD || cmd == CMD_REWIND) |=> !in_stall)
		else $error("load or rewind stalled input");
endmodule

bind envelope_sine_stimulus ess_checker u_ess_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.cmd       (cmd),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.stim_value(stim_value),
	.active    (active)
);
`default_nettype wire

// File: sim/envelope_sine_stimulus_tb.sv
`timescale 1ns / 100ps
module envelope_sine_stimulus_tb;
	import ess_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;	// not decoded by the block, must be dropped
	localparam int DEPTH = 64;
	localparam int SETTLE = 400;			// worst tick: full walk + divide + sine
	localparam int CYCLE_LIMIT = 2_000_000;

	typedef struct {
		logic signed [31:0] value;
		logic               act;
	} stim_t;

	// directed row: either a config write or an input beat, optionally with a typed result
	typedef struct {
		bit                 is_cfg;
		logic [1:0]         idx;
		logic [31:0]        data;
		logic [1:0]         c;
		logic [31:0]        nw;
		logic [5:0]         sl;
		logic [31:0]        pt;
		logic [31:0]        pa;
		bit                 typed;
		logic [31:0]        tval;
		logic               tact;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = '0;
	logic [31:0] now_time = '0;
	logic [5:0] point_slot = '0;
	logic [31:0] point_time = '0;
	logic signed [31:0] point_amplitude = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] stim_value;
	logic active;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	envelope_sine_stimulus #(.ENV_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .now_time(now_time),
		.point_slot(point_slot), .point_time(point_time), .point_amplitude(point_amplitude),
		.out_valid(out_valid), .out_stall(out_stall), .stim_value(stim_value),
		.active(active),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the channel
	logic [31:0] pt_times [DEPTH];
	logic [31:0] pt_amps [DEPTH];
	int unsigned env_pos;
	logic [6:0] pt_count;
	logic [31:0] freq_q32;
	logic [31:0] phase_q32;

	stim_t pending_stim[$];	// results owed by the block, oldest first
	int errors = 0;
	int idle_pct = 0;		// sender gap probability, percent
	int stall_pct = 0;		// receiver stall probability, percent
	bit long_hold = 1'b0;	// request one long receiver hold-off
	longint unsigned cycles = 0;

	// sine of a Q0.32 angle, Q2.30 result
	function automatic longint sine_q30(input logic [31:0] p);
		logic [63:0] x, x2, t, s;
		x = {34'd0, p[29:0]};
		if (p[30])
			x = 64'd1073741824 - x;
		x2 = (x * x) >> 30;
		t = 64'(SIN_B) - ((64'(SIN_C) * x2) >> 30);
		t = 64'(SIN_A) - ((t * x2) >> 30);
		s = (t * x) >> 30;
		return p[31] ? -longint'(s) : longint'(s);
	endfunction

	// linear segment value, quotient magnitude truncated
	function automatic longint lerp_amp(input longint a0, input longint a1,
			input logic [31:0] t0, input logic [31:0] t1, input logic [31:0] nw);
		longint num, den, diff;
		longint unsigned mag, q;
		num = longint'(nw) - longint'(t0);
		den = longint'(t1) - longint'(t0);
		diff = a1 - a0;
		if (num <= 0)
			return a0;
		mag = longint'(diff < 0 ? -diff : diff) * longint'(num);
		q = mag / longint'(den);
		return diff < 0 ? a0 - longint'(q) : a0 + longint'(q);
	endfunction

	function automatic stim_t envelope_at(input logic [31:0] nw);
		stim_t r;
		int unsigned n;
		longint v, prod, m;
		logic [31:0] ang;
		n = (pt_count > DEPTH) ? DEPTH : pt_count;
		r.value = '0;
		r.act = 1'b0;
		if (n == 0 || nw < pt_times[0])
			return r;
		if (env_pos >= n)
			env_pos = n - 1;
		while (env_pos + 1 < n && pt_times[env_pos + 1] <= nw)
			env_pos++;
		v = longint'(signed'(pt_amps[env_pos]));
		if (env_pos + 1 < n)
			v = lerp_amp(v, longint'(signed'(pt_amps[env_pos + 1])),
				pt_times[env_pos], pt_times[env_pos + 1], nw);
		if (freq_q32 != 0) begin
			ang = freq_q32 * nw + phase_q32;
			prod = v * sine_q30(ang);
			m = (prod < 0 ? -prod : prod) >>> 30;
			v = prod < 0 ? -m : m;
			if (v > 64'sd2147483647)
				v = 64'sd2147483647;
			if (v < -64'sd2147483648)
				v = -64'sd2147483648;
		end
		r.value = v[31:0];
		r.act = 1'b1;
		return r;
	endfunction

	// drive one beat after an optional gap; shadow state follows at acceptance
	task automatic send_beat(input logic [1:0] c, input logic [31:0] nw, input logic [5:0] sl,
			input logic [31:0] pt, input logic [31:0] pa);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < idle_pct)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		now_time <= nw;
		point_slot <= sl;
		point_time <= pt;
		point_amplitude <= pa;
		do @(posedge clk); while (in_stall);
		case (c)
			CMD_LOAD: begin
				pt_times[sl] = pt;
				pt_amps[sl] = pa;
			end
			CMD_REWIND: env_pos = 0;
			CMD_TICK: pending_stim.insert(pending_stim.size(), envelope_at(nw));
			default: ;
		endcase
	endtask

	// sender pause: drop valid, drain all results, then let any load/rewind finish
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_stim.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_POINT_COUNT: pt_count = data[6:0];
			REG_MOD_FREQ: freq_q32 = data;
			REG_MOD_PHASE: phase_q32 = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		stim_t e;
		if (out_valid && !out_stall) begin
			if (pending_stim.size() == 0) begin
				$display("%0t: unexpected result value=%h active=%b", $time, stim_value, active);
				errors++;
			end else begin
				e = pending_stim.pop_front();
				if (stim_value !== e.value) begin
					$display("%0t: stim_value expected %h actual %h", $time, e.value, stim_value);
					errors++;
				end
				if (active !== e.act) begin
					$display("%0t: active expected %b actual %b", $time, e.act, active);
					errors++;
				end
			end
		end
	end

	// receiver backpressure: short random stalls, rare long ones, one forced long hold-off
	always @(posedge clk) begin
		int hold_left;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (long_hold) begin
			long_hold = 1'b0;
			hold_left = 600;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			hold_left = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	row_t rows[$];

	function automatic row_t beat_row(input logic [1:0] c, input logic [31:0] nw,
			input logic [5:0] sl, input logic [31:0] pt, input logic [31:0] pa);
		row_t r;
		r = '{default: '0};
		r.c = c; r.nw = nw; r.sl = sl; r.pt = pt; r.pa = pa;
		return r;
	endfunction

	function automatic row_t cfg_row(input logic [1:0] idx, input logic [31:0] data);
		row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1; r.idx = idx; r.data = data;
		return r;
	endfunction

	function automatic row_t tick_row(input logic [31:0] nw, input bit typed,
			input logic [31:0] tv, input logic ta);
		row_t r;
		r = beat_row(CMD_TICK, nw, '0, '0, '0);
		r.typed = typed; r.tval = tv; r.tact = ta;
		return r;
	endfunction

	// append one row to the directed table
	function automatic void add_row(input row_t r);
		rows.insert(rows.size(), r);
	endfunction

	initial begin
		logic [31:0] tnow, tbase;
		int unsigned n_beats, sel;
		logic [6:0] counts [8] = '{7'd64, 7'd2, 7'd127, 7'd1, 7'd64, 7'd0, 7'd33, 7'd64};

		for (int i = 0; i < DEPTH; i++) begin
			pt_times[i] = '0;
			pt_amps[i] = '0;
		end
		env_pos = 0;
		pt_count = '0;
		freq_q32 = '0;
		phase_q32 = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: empty envelope, field extremes, hold, interpolation, modulation
		add_row(tick_row(32'd0, 1, 32'd0, 1'b0));			// empty after reset
		add_row(tick_row(32'hFFFF_FFFF, 1, 32'd0, 1'b0));
		add_row(beat_row(CMD_UNUSED, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		add_row(beat_row(CMD_LOAD, '0, 6'd0, 32'd100, 32'h7FFF_FFFF));
		add_row(beat_row(CMD_LOAD, '0, 6'd1, 32'd200, 32'h8000_0000));
		add_row(beat_row(CMD_LOAD, '0, 6'd63, 32'hFFFF_FFFF, 32'h0001_2345));
		add_row(beat_row(CMD_REWIND, '0, '0, '0, '0));
		add_row(tick_row(32'd50, 1, 32'd0, 1'b0));			// still empty
		add_row(cfg_row(REG_POINT_COUNT, 32'd1));
		add_row(tick_row(32'd50, 1, 32'd0, 1'b0));			// before first point
		add_row(tick_row(32'd100, 1, 32'h7FFF_FFFF, 1'b1));	// held single point
		add_row(cfg_row(REG_POINT_COUNT, 32'd2));
		add_row(tick_row(32'd150, 0, '0, '0));				// mid segment
		add_row(tick_row(32'd200, 1, 32'h8000_0000, 1'b1));	// held last point
		add_row(tick_row(32'd120, 0, '0, '0));				// time went back
		add_row(beat_row(CMD_REWIND, '0, '0, '0, '0));
		add_row(tick_row(32'd199, 0, '0, '0));
		add_row(cfg_row(REG_MOD_FREQ, 32'h4000_0000));		// quarter turn per time unit
		add_row(tick_row(32'd100, 1, 32'd0, 1'b1));			// angle wraps to zero
		add_row(tick_row(32'd101, 0, '0, '0));
		add_row(cfg_row(REG_MOD_FREQ, 32'hFFFF_FFFF));
		add_row(cfg_row(REG_MOD_PHASE, 32'hFFFF_FFFF));
		add_row(tick_row(32'd200, 0, '0, '0));				// saturating corner area
		add_row(tick_row(32'd150, 0, '0, '0));

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				drain();
				write_reg(rows[i].idx, rows[i].data);
			end else begin
				send_beat(rows[i].c, rows[i].nw, rows[i].sl, rows[i].pt, rows[i].pa);
				if (rows[i].typed)
					pending_stim[pending_stim.size() - 1] = '{rows[i].tval, rows[i].tact};
			end
		end

		// fill the whole store with a sorted envelope, some points sharing a time
		idle_pct = 20;
		stall_pct = 20;
		tbase = 32'd0;
		for (int i = 0; i < DEPTH; i++) begin
			if ($urandom_range(0, 5) != 0)
				tbase = tbase + $urandom_range(1, 1999);
			send_beat(CMD_LOAD, $urandom, i[5:0], tbase, $urandom);
		end

		// random phases over several register settings
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			write_reg(REG_POINT_COUNT, {25'd0, counts[ph]});
			case (ph % 4)
				0: write_reg(REG_MOD_FREQ, 32'd0);
				1: write_reg(REG_MOD_FREQ, 32'hFFFF_FFFF);
				2: write_reg(REG_MOD_FREQ, $urandom_range(1, 1 << 20));
				default: write_reg(REG_MOD_FREQ, $urandom);
			endcase
			write_reg(REG_MOD_PHASE, (ph == 1) ? 32'hFFFF_FFFF : (ph == 4) ? 32'd0 : $urandom);
			// some phases run without any idling at all
			idle_pct = (ph == 2 || ph == 5) ? 0 : $urandom_range(10, 50);
			stall_pct = (ph == 2 || ph == 6) ? 0 : $urandom_range(10, 50);
			if (ph == 3) begin
				idle_pct = 0;
				long_hold = 1'b1;	// block fills up and stalls its input
			end
			tnow = 32'd0;
			n_beats = 68;
			for (int k = 0; k < n_beats; k++) begin
				sel = $urandom_range(0, 99);
				if (sel < 75) begin
					tnow = tnow + $urandom_range(0, 1500);
					send_beat(CMD_TICK, tnow, 6'($urandom), $urandom, $urandom);
				end else if (sel < 83) begin
					send_beat(CMD_TICK, $urandom, 6'($urandom), $urandom, $urandom);
				end else if (sel < 90) begin
					tnow = $urandom_range(0, 800);
					send_beat(CMD_REWIND, $urandom, 6'($urandom), $urandom, $urandom);
				end else if (sel < 97) begin
					// unsorted point: exercises the earlier-than-current path
					send_beat(CMD_LOAD, $urandom, 6'($urandom), $urandom_range(0, 140000),
						$urandom);
				end else begin
					send_beat(CMD_UNUSED, $urandom, 6'($urandom), $urandom, $urandom);
					k--;
				end
				if (tnow > 32'd140000)
					tnow = 32'd0;
			end
		end

		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: filelist.f
sv/ess_pkg.sv
sv/ess_ram.sv
sv/ess_datapath.sv
sv/ess_ctrl.sv
sv/envelope_sine_stimulus.sv
sv/ess_checker.sv
sim/envelope_sine_stimulus_tb.sv
